### design/rp8_pkg.sv
// Shared constants, types and config record for the raw pixel to RGBA8 converter.
package rp8_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int NUM_CH       = 4;
  localparam int Q_W          = 8;                    // quotient bits, one per cell
  localparam int RNG_W        = 32;                   // range up to 2^31 - 1
  localparam int ACC_W        = RNG_W + 1 + Q_W;      // remainder / shifted divisor
  localparam int NUM_CELLS    = Q_W;
  localparam int ADDR_W       = 6;
  localparam int DATA_W       = 64;
  localparam int SCALE_MUL    = 510;                  // 2 * 255

  typedef enum logic [2:0] {
    REG_MODE  = 3'd0,
    REG_SIGB  = 3'd1,
    REG_CFA   = 3'd2,
    REG_USE   = 3'd3,
    REG_BLACK = 3'd4,
    REG_WHITE = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_RAW  = 2'd0,
    MODE_RGB  = 2'd1,
    MODE_RGBA = 2'd2,
    MODE_RSVD = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFA_RED   = 2'd0,
    CFA_GREEN = 2'd1,
    CFA_BLUE  = 2'd2,
    CFA_GRAY  = 2'd3
  } cfa_code_t;

  typedef struct packed {
    logic [1:0]  channel_mode;
    logic [4:0]  significant_bits;
    logic [7:0]  cfa_map;
    logic        cfa_color_en;
    logic [63:0] blk_lvls;
    logic [63:0] wht_lvls;
  } cfg_t;

  typedef struct packed {
    logic [ACC_W-1:0] rem;
    logic [ACC_W-1:0] dvs;
    logic [Q_W-1:0]   q;
  } lane_t;

  typedef struct packed {
    lane_t [NUM_CH-1:0] lane;
    logic               raw;
    logic               alpha_en;
    logic [7:0]         raw_r;
    logic [7:0]         raw_g;
    logic [7:0]         raw_b;
  } cell_t;

endpackage

### design/rp8_in_if.sv
// Input pixel channel.
interface rp8_in_if;
  logic                          valid;
  logic                          ready;
  logic [rp8_pkg::SAMPLE_WIDTH-1:0] sample_zero;
  logic [rp8_pkg::SAMPLE_WIDTH-1:0] sample_one;
  logic [rp8_pkg::SAMPLE_WIDTH-1:0] sample_two;
  logic [rp8_pkg::SAMPLE_WIDTH-1:0] sample_three;
  logic                          column_odd;
  logic                          row_odd;
  modport source (output valid, sample_zero, sample_one, sample_two, sample_three,
                  column_odd, row_odd, input ready);
  modport sink   (input valid, sample_zero, sample_one, sample_two, sample_three,
                  column_odd, row_odd, output ready);
endinterface

### design/rp8_out_if.sv
// Result pixel channel.
interface rp8_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

### design/rp8_prep.sv
// Head cell: black/white handling, raw path, divider operand setup.
module rp8_prep (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rp8_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rp8_pkg::SAMPLE_WIDTH-1:0] s0,
  input  logic [rp8_pkg::SAMPLE_WIDTH-1:0] s1,
  input  logic [rp8_pkg::SAMPLE_WIDTH-1:0] s2,
  input  logic [rp8_pkg::SAMPLE_WIDTH-1:0] s3,
  input  logic                          col_odd,
  input  logic                          row_odd,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rp8_pkg::cell_t                out_data
);
  import rp8_pkg::*;

  logic  valid_r, valid_nxt;
  cell_t data_r, data_nxt;
  logic [SAMPLE_WIDTH-1:0] smp [NUM_CH];

  assign smp[0] = s0;
  assign smp[1] = s1;
  assign smp[2] = s2;
  assign smp[3] = s3;

  function automatic lane_t setup_lane(input logic [15:0] sample, input logic [15:0] black,
                                       input logic [15:0] white, input logic [4:0] bits);
    logic [RNG_W-1:0] wht;
    logic [RNG_W-1:0] blk1;
    logic [RNG_W-1:0] rng;
    logic [15:0]      num;
    logic [ACC_W-1:0] numer;
    lane_t            l;
    blk1 = RNG_W'(black) + RNG_W'(1);
    if (white <= black) begin
      if (bits == 5'd0) wht = RNG_W'(255);
      else              wht = RNG_W'((33'd1 << bits) - 33'd1);
    end else begin
      wht = RNG_W'(white);
    end
    if (wht < blk1) wht = blk1;
    rng = wht - RNG_W'(black);
    num = (sample > black) ? sample - black : 16'd0;
    if (RNG_W'(num) > rng) num = rng[15:0];
    numer = ACC_W'(num) * ACC_W'(SCALE_MUL) + ACC_W'(rng);
    l.rem = numer;
    l.dvs = ACC_W'(rng) << Q_W;         // 2*range aligned to the top quotient bit
    l.q   = '0;
    return l;
  endfunction

  logic [4:0] bits;
  logic [SAMPLE_WIDTH-1:0] shifted;
  logic [7:0] raw_v;
  logic [1:0] code;

  always_comb begin
    bits = cfg.significant_bits;
    shifted = (bits > 5'd8) ? (s0 >> (bits - 5'd8)) : s0;
    raw_v = (shifted > SAMPLE_WIDTH'(255)) ? 8'hFF : shifted[7:0];
    code = cfg.cfa_color_en ? cfg.cfa_map[{row_odd, col_odd, 1'b0} +: 2] : CFA_GRAY;
    for (int c = 0; c < NUM_CH; c++) begin
      data_nxt.lane[c] = setup_lane(smp[c], cfg.blk_lvls[16*c +: 16],
                                    cfg.wht_lvls[16*c +: 16], bits);
    end
    data_nxt.raw      = (cfg.channel_mode == MODE_RAW);
    data_nxt.alpha_en = (cfg.channel_mode == MODE_RGBA);
    data_nxt.raw_r    = (code == CFA_RED   || code == CFA_GRAY) ? raw_v : 8'd0;
    data_nxt.raw_g    = (code == CFA_GREEN || code == CFA_GRAY) ? raw_v : 8'd0;
    data_nxt.raw_b    = (code == CFA_BLUE  || code == CFA_GRAY) ? raw_v : 8'd0;
  end

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;
endmodule

### design/rp8_div_cell.sv
// Divider cell: one restoring quotient bit for all four channels.
module rp8_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rp8_pkg::cell_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rp8_pkg::cell_t out_data
);
  import rp8_pkg::*;

  logic  valid_r;
  cell_t data_r, data_nxt;

  always_comb begin
    data_nxt = in_data;
    for (int c = 0; c < NUM_CH; c++) begin
      if (in_data.lane[c].rem >= in_data.lane[c].dvs) begin
        data_nxt.lane[c].rem = in_data.lane[c].rem - in_data.lane[c].dvs;
        data_nxt.lane[c].q   = {in_data.lane[c].q[Q_W-2:0], 1'b1};
      end else begin
        data_nxt.lane[c].q   = {in_data.lane[c].q[Q_W-2:0], 1'b0};
      end
      data_nxt.lane[c].dvs = in_data.lane[c].dvs >> 1;
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n)        valid_r <= 1'b0;
    else if (in_ready) valid_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;
endmodule

### design/raw_pixel_to_rgba8_top.sv
// Top level: config registers and the cell chain of the raw pixel to RGBA8 converter.
//
//  port      dir   beat contents
//  in_pix    sink  sample_zero..three (16b), column_odd, row_odd
//  out_pix   src   red, green, blue, alpha (8b each)
//  cfg_*     APB   6 regs, 64b data, reg i at byte 8*i
//
// One pixel per clock sustained while the output is ready: a setup cell, then eight
// divider cells each resolving one quotient bit for all four channels.
// The last cell's register is the output register.
// Each cell takes a new beat when it is empty or its neighbor takes its beat,
// so bubbles close up and a stalled output only blocks once the chain is full.
// rst_n (synchronous) clears every cell valid and loads register defaults.
module raw_pixel_to_rgba8_top (
  input  logic                          clk,
  input  logic                          rst_n,
  rp8_in_if.sink                        in_pix,
  rp8_out_if.source                     out_pix,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [rp8_pkg::ADDR_W-1:0]    cfg_paddr,
  input  logic [rp8_pkg::DATA_W-1:0]    cfg_pwdata,
  output logic [rp8_pkg::DATA_W-1:0]    cfg_prdata,
  output logic                          cfg_pready
);
  import rp8_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t widx;

  assign cfg_pready = 1'b1;
  assign widx = reg_idx_t'(cfg_paddr[ADDR_W-1:3]);

  // register file, written in the APB access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.channel_mode     <= MODE_RAW;
      cfg_r.significant_bits <= 5'd16;
      cfg_r.cfa_map          <= 8'd228;
      cfg_r.cfa_color_en     <= 1'b1;
      cfg_r.blk_lvls         <= '0;
      cfg_r.wht_lvls         <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (widx)
        REG_MODE:  cfg_r.channel_mode     <= cfg_pwdata[1:0];
        REG_SIGB:  cfg_r.significant_bits <= cfg_pwdata[4:0];
        REG_CFA:   cfg_r.cfa_map          <= cfg_pwdata[7:0];
        REG_USE:   cfg_r.cfa_color_en     <= cfg_pwdata[0];
        REG_BLACK: cfg_r.blk_lvls         <= cfg_pwdata;
        REG_WHITE: cfg_r.wht_lvls         <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_MODE:  cfg_prdata = DATA_W'(cfg_r.channel_mode);
      REG_SIGB:  cfg_prdata = DATA_W'(cfg_r.significant_bits);
      REG_CFA:   cfg_prdata = DATA_W'(cfg_r.cfa_map);
      REG_USE:   cfg_prdata = DATA_W'(cfg_r.cfa_color_en);
      REG_BLACK: cfg_prdata = cfg_r.blk_lvls;
      REG_WHITE: cfg_prdata = cfg_r.wht_lvls;
      default:   cfg_prdata = '0;
    endcase
  end

  // chain: index 0 is the setup cell, 1..NUM_CELLS the divider cells
  logic  vld [NUM_CELLS+1];
  logic  rdy [NUM_CELLS+2];
  cell_t dat [NUM_CELLS+1];

  rp8_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_pix.valid),
    .in_ready  (rdy[0]),
    .s0        (in_pix.sample_zero),
    .s1        (in_pix.sample_one),
    .s2        (in_pix.sample_two),
    .s3        (in_pix.sample_three),
    .col_odd   (in_pix.column_odd),
    .row_odd   (in_pix.row_odd),
    .out_valid (vld[0]),
    .out_ready (rdy[1]),
    .out_data  (dat[0])
  );

  assign in_pix.ready = rdy[0];

  for (genvar k = 1; k <= NUM_CELLS; k++) begin : g_cell
    rp8_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vld[k-1]),
      .in_ready  (rdy[k]),
      .in_data   (dat[k-1]),
      .out_valid (vld[k]),
      .out_ready (rdy[k+1]),
      .out_data  (dat[k])
    );
  end

  assign rdy[NUM_CELLS+1] = out_pix.ready;

  // quotient lanes or the raw-plane bytes, alpha forced opaque unless RGBA
  assign out_pix.valid = vld[NUM_CELLS];
  assign out_pix.red   = dat[NUM_CELLS].raw ? dat[NUM_CELLS].raw_r : dat[NUM_CELLS].lane[0].q;
  assign out_pix.green = dat[NUM_CELLS].raw ? dat[NUM_CELLS].raw_g : dat[NUM_CELLS].lane[1].q;
  assign out_pix.blue  = dat[NUM_CELLS].raw ? dat[NUM_CELLS].raw_b : dat[NUM_CELLS].lane[2].q;
  assign out_pix.alpha = dat[NUM_CELLS].alpha_en ? dat[NUM_CELLS].lane[3].q : 8'hFF;

  // an empty output cell lets the whole chain advance
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !vld[NUM_CELLS] |-> in_pix.ready)
    else $error("input stalled with empty output cell");

  a_alpha_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pix.valid && !dat[NUM_CELLS].alpha_en) |-> out_pix.alpha == 8'hFF)
    else $error("alpha not opaque outside RGBA mode");

  a_raw_gray: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pix.valid && cfg_r.channel_mode == MODE_RAW && !cfg_r.cfa_color_en)
      |-> (out_pix.red == out_pix.green && out_pix.green == out_pix.blue))
    else $error("raw gray output not equal across channels");
endmodule

### tb/tb_raw_pixel_to_rgba8_top.sv
// Testbench for the raw pixel to RGBA8 converter: random pixels, config phases, scoreboard.
module tb_raw_pixel_to_rgba8_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rp8_pkg::*;

  typedef struct {
    logic [15:0] s0, s1, s2, s3;
    logic        col, row;
  } pixel_t;

  typedef struct {
    logic [7:0] r, g, b, a;
  } rgba_t;

  logic clk = 0;
  logic rst_n = 0;
  always #2 clk = ~clk;

  rp8_in_if  pix_in ();
  rp8_out_if pix_out ();

  logic              cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [DATA_W-1:0] cfg_pwdata = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  raw_pixel_to_rgba8_top u_dut (
    .clk(clk), .rst_n(rst_n), .in_pix(pix_in.sink), .out_pix(pix_out.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // shadow copy of the config registers
  logic [1:0]  m_mode = MODE_RAW;
  logic [4:0]  m_sigb = 5'd16;
  logic [7:0]  m_cfa  = 8'd228;
  logic        m_use  = 1'b1;
  logic [63:0] m_black = '0, m_white = '0;

  pixel_t pending_pix[$];
  rgba_t  expected_rgba[$];
  int     mismatches = 0;
  bit     stall_en = 1;     // random idling on; cleared for the tail of the run
  bit     hold_off = 0;     // long receiver hold-off

  // black-level subtract, clamp and round-half-up scale of one channel
  function automatic logic [7:0] norm_channel(logic [15:0] s, int ch);
    logic [63:0] blk, wht, rng, num, q;
    blk = (m_black >> (16*ch)) & 64'hFFFF;
    wht = (m_white >> (16*ch)) & 64'hFFFF;
    if (wht <= blk) wht = (m_sigb == 0) ? 64'd255 : ((64'd1 << m_sigb) - 1);
    if (wht < blk + 1) wht = blk + 1;
    rng = wht - blk;
    num = (s > blk) ? s - blk : 0;
    if (num > rng) num = rng;
    q = (2*num*255 + rng) / (2*rng);
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic rgba_t convert_pixel(pixel_t p);
    rgba_t o;
    logic [63:0] v;
    logic [1:0] code;
    o.a = 8'd255;
    if (m_mode == MODE_RAW) begin
      v = p.s0;
      if (m_sigb > 8) v = v >> (m_sigb - 8);
      if (v > 255) v = 255;
      code = m_use ? m_cfa[2*(2*p.row + p.col) +: 2] : CFA_GRAY;
      o.r = (code == CFA_RED   || code == CFA_GRAY) ? v[7:0] : 8'd0;
      o.g = (code == CFA_GREEN || code == CFA_GRAY) ? v[7:0] : 8'd0;
      o.b = (code == CFA_BLUE  || code == CFA_GRAY) ? v[7:0] : 8'd0;
    end else begin
      o.r = norm_channel(p.s0, 0);
      o.g = norm_channel(p.s1, 1);
      o.b = norm_channel(p.s2, 2);
      if (m_mode == MODE_RGBA) o.a = norm_channel(p.s3, 3);
    end
    return o;
  endfunction

  // driver: idle bursts between beats; valid stays up while the DUT stalls
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      pix_in.valid <= 0;
    end else begin
      if (pix_in.valid && pix_in.ready) begin
        expected_rgba = {expected_rgba, convert_pixel(pending_pix.pop_front())};
      end
      if (pix_in.valid && !pix_in.ready) begin
        // hold the beat
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        pix_in.valid <= 0;
      end else if (stall_en && $urandom_range(0, 5) == 0) begin
        send_gap <= $urandom_range(0, 7);
        pix_in.valid <= 0;
      end else begin
        // a taken beat is already popped, so the head is the next one
        if (pending_pix.size() > 0) begin
          pix_in.valid        <= 1;
          pix_in.sample_zero  <= pending_pix[0].s0;
          pix_in.sample_one   <= pending_pix[0].s1;
          pix_in.sample_two   <= pending_pix[0].s2;
          pix_in.sample_three <= pending_pix[0].s3;
          pix_in.column_odd   <= pending_pix[0].col;
          pix_in.row_odd      <= pending_pix[0].row;
        end else begin
          pix_in.valid <= 0;
        end
      end
    end
  end

  initial begin
    pix_in.valid = 0; pix_in.sample_zero = 0; pix_in.sample_one = 0;
    pix_in.sample_two = 0; pix_in.sample_three = 0;
    pix_in.column_odd = 0; pix_in.row_odd = 0;
    pix_out.ready = 0;
  end

  // monitor and receiver-side stalls
  int recv_gap = 0;
  always @(posedge clk) begin
    rgba_t e;
    if (rst_n) begin
      if (pix_out.valid && pix_out.ready) begin
        if (expected_rgba.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected output beat %h %h %h %h",
            pix_out.red, pix_out.green, pix_out.blue, pix_out.alpha);
        end else begin
          e = expected_rgba.pop_front();
          if (e.r !== pix_out.red || e.g !== pix_out.green ||
              e.b !== pix_out.blue || e.a !== pix_out.alpha) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pixel mismatch: exp r%h g%h b%h a%h got r%h g%h b%h a%h",
                e.r, e.g, e.b, e.a, pix_out.red, pix_out.green, pix_out.blue,
                pix_out.alpha);
          end
        end
      end
      if (hold_off) begin
        pix_out.ready <= 0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        pix_out.ready <= 0;
      end else if (stall_en && $urandom_range(0, 5) == 0) begin
        recv_gap <= $urandom_range(0, 7);
        pix_out.ready <= 0;
      end else begin
        pix_out.ready <= 1;
      end
    end
  end

  // two-phase APB write, shadow updated alongside
  task automatic reg_write(reg_idx_t idx, logic [63:0] val);
    @(posedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_penable <= 0;
    cfg_paddr <= ADDR_W'(8 * int'(idx)); cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    case (idx)
      REG_MODE:  m_mode  = val[1:0];
      REG_SIGB:  m_sigb  = val[4:0];
      REG_CFA:   m_cfa   = val[7:0];
      REG_USE:   m_use   = val[0];
      REG_BLACK: m_black = val;
      REG_WHITE: m_white = val;
      default: ;
    endcase
  endtask

  // block drained: nothing queued, nothing outstanding, pipeline flushed
  task automatic drain();
    while (pending_pix.size() != 0 || pix_in.valid || expected_rgba.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p.s0 = 16'($urandom); p.s1 = 16'($urandom); p.s2 = 16'($urandom);
    p.s3 = 16'($urandom);
    p.col = 1'($urandom); p.row = 1'($urandom);
    if ($urandom_range(0, 3) == 0) p.s0 = 16'($urandom_range(0, 300));
    return p;
  endfunction

  function automatic logic [63:0] rand_levels();
    logic [63:0] v;
    for (int c = 0; c < 4; c++)
      v[16*c +: 16] = ($urandom_range(0, 2) == 0) ? 16'($urandom) :
                      16'($urandom_range(0, 4095));
    return v;
  endfunction

  task automatic push_pix(logic [15:0] a, b, c, d, logic col, row);
    pixel_t p;
    p.s0 = a; p.s1 = b; p.s2 = c; p.s3 = d; p.col = col; p.row = row;
    pending_pix = {pending_pix, p};
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1;

    // directed: raw mode at reset defaults, every parity and extreme samples
    for (int i = 0; i < 4; i++) push_pix(16'hFFFF, 0, 0, 0, i[0], i[1]);
    push_pix(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0);
    push_pix(16'h8000, 0, 0, 0, 1, 1);
    drain();
    // few significant bits: no shift, saturation; gray display
    reg_write(REG_SIGB, 5);
    reg_write(REG_USE, 0);
    push_pix(16'd200, 0, 0, 0, 0, 1);
    push_pix(16'd300, 0, 0, 0, 1, 0);
    drain();
    // wide significant bits and a pattern using the gray code
    reg_write(REG_SIGB, 31);
    reg_write(REG_USE, 1);
    reg_write(REG_CFA, 8'hFF);
    push_pix(16'hFFFF, 0, 0, 0, 0, 0);
    drain();
    reg_write(REG_SIGB, 0);
    push_pix(16'hFFFF, 0, 0, 0, 1, 1);
    drain();
    // RGBA with white not above black, black at max
    reg_write(REG_MODE, MODE_RGBA);
    reg_write(REG_SIGB, 12);
    reg_write(REG_BLACK, 64'hFFFF_0100_0000_0010);
    reg_write(REG_WHITE, 64'h0000_0100_FFFF_0FFF);
    push_pix(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0);
    push_pix(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 1);
    push_pix(16'h0808, 16'h0180, 16'h7FFF, 16'hFFFE, 0, 1);
    drain();
    // unused mode acts as RGB
    reg_write(REG_MODE, MODE_RSVD);
    push_pix(16'h1234, 16'h0100, 16'h8000, 16'hFFFF, 1, 0);
    drain();
    reg_write(REG_MODE, MODE_RGB);
    push_pix(16'h1234, 16'h0100, 16'h8000, 16'hFFFF, 1, 0);
    drain();

    // random phases with fresh settings
    for (int ph = 0; ph < 8; ph++) begin
      reg_write(REG_MODE, $urandom_range(0, 3));
      reg_write(REG_SIGB, (ph == 0) ? 16 : (ph == 1) ? 1 : $urandom_range(0, 31));
      reg_write(REG_CFA, $urandom_range(0, 255));
      reg_write(REG_USE, $urandom_range(0, 1));
      reg_write(REG_BLACK, (ph == 2) ? 64'hFFFF_FFFF_FFFF_FFFF : rand_levels());
      reg_write(REG_WHITE, (ph == 3) ? 64'hFFFF_FFFF_FFFF_FFFF : rand_levels());
      if (ph == 7) stall_en = 0;   // tail runs at full rate
      for (int i = 0; i < 100; i++) pending_pix = {pending_pix, rand_pixel()};
      if (ph == 4) begin
        // receiver holds off so the chain fills and back-pressures the input
        @(posedge clk);
        hold_off = 1;
        repeat (60) @(posedge clk);
        hold_off = 0;
      end
      drain();
    end

    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end
endmodule
